// ----- rtl/bst_pkg.sv -----
// Shared types, codes and constants for the breakpoint slot table.
// No dependencies; every other file in rtl/ imports this package.
package bst_pkg;

    // Default number of breakpoint slots.
    localparam int SLOTS_DEFAULT = 32;

    // Depth of the command queue between front and engine.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Fixed instruction words and address rules.
    localparam logic [31:0] BRK_PLAIN  = 32'hD420_0000;
    localparam logic [31:0] BRK_DEBUG  = 32'hD420_0020;
    localparam logic [63:0] ALIGN_MASK = 64'h3;
    localparam logic [63:0] INSN_BYTES = 64'd4;

    // Command codes on the input tuser.
    typedef enum logic [2:0] {
        CMD_SET     = 3'd0,
        CMD_DELETE  = 3'd1,
        CMD_ENABLE  = 3'd2,
        CMD_DISABLE = 3'd3,
        CMD_HIT     = 3'd4
    } cmd_e_t;

    // Result status codes on the output tuser.
    typedef enum logic [2:0] {
        STAT_OK         = 3'd0,
        STAT_MISALIGNED = 3'd1,
        STAT_FULL       = 3'd2,
        STAT_BAD        = 3'd3,
        STAT_FAULT      = 3'd4,
        STAT_UNKNOWN    = 3'd5
    } status_t;

    // Slot modes.
    typedef enum logic [1:0] {
        MODE_FREE      = 2'd0,
        MODE_ACTIVE    = 2'd1,
        MODE_SUSPENDED = 2'd2
    } mode_t;

    // Work kinds after classification by the front.
    typedef enum logic [2:0] {
        KIND_ERR     = 3'd0,
        KIND_SET     = 3'd1,
        KIND_DELETE  = 3'd2,
        KIND_ENABLE  = 3'd3,
        KIND_DISABLE = 3'd4,
        KIND_HIT     = 3'd5
    } kind_t;

    // Classified command as it travels through the queue.
    typedef struct packed {
        kind_t       kind;
        status_t     err_status;
        logic [63:0] address;    // set address, or pc minus 4 for a hit
        logic        temporary;
        logic [5:0]  handle;
        logic [31:0] word;
        logic        fetch_ok;
        logic        is_brk;     // word is one of the fixed breakpoint words
    } item_t;

    // One result beat.
    typedef struct packed {
        status_t     status;
        logic [5:0]  handle_out;
        logic        enter_debugger;
        logic        patch_write;
        logic [63:0] patch_address;
        logic [31:0] patch_word;
        logic [31:0] hit_total;
    } result_t;

endpackage

// ----- rtl/bst_front.sv -----
// Input front end of the breakpoint slot table: unpacks the input beat,
// classifies the command and pushes it into the queue. Depends on bst_pkg.
module bst_front import bst_pkg::*; #(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // address, temporary, handle, fetched_word, fetch_ok
    input  logic [2:0]   s_tuser,   // command
    input  logic         q_full,
    output logic         q_push,
    output item_t        q_item
);

    localparam logic [8:0] SLOTS_W9 = 9'(SLOTS);

    logic [63:0] address;
    logic        temporary;
    logic [5:0]  handle;
    logic [31:0] word;
    logic        fetch_ok;
    logic        handle_ok;

    // Field unpacking.
    assign address   = s_tdata[63:0];
    assign temporary = s_tdata[64];
    assign handle    = s_tdata[70:65];
    assign word      = s_tdata[102:71];
    assign fetch_ok  = s_tdata[103];

    // A beat is taken whenever the queue has room.
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    assign handle_ok = (handle != 6'd0) && ({3'b000, handle} <= SLOTS_W9);

    // Classify the command; errors that need no table lookup are settled here.
    always_comb begin
        q_item            = '0;
        q_item.kind       = KIND_ERR;
        q_item.err_status = STAT_BAD;
        q_item.address    = address;
        q_item.temporary  = temporary;
        q_item.handle     = handle;
        q_item.word       = word;
        q_item.fetch_ok   = fetch_ok;
        q_item.is_brk     = (word == BRK_PLAIN) || (word == BRK_DEBUG);
        case (cmd_e_t'(s_tuser))
            CMD_SET: begin
                if ((address & ALIGN_MASK) != 64'd0) begin
                    q_item.err_status = STAT_MISALIGNED;
                end else begin
                    q_item.kind = KIND_SET;
                end
            end
            CMD_DELETE: begin
                if (handle_ok) q_item.kind = KIND_DELETE;
            end
            CMD_ENABLE: begin
                if (handle_ok) q_item.kind = KIND_ENABLE;
            end
            CMD_DISABLE: begin
                if (handle_ok) q_item.kind = KIND_DISABLE;
            end
            CMD_HIT: begin
                q_item.kind    = KIND_HIT;
                q_item.address = address - INSN_BYTES;
            end
            default: begin
                q_item.kind = KIND_ERR;
            end
        endcase
    end

endmodule

// ----- rtl/bst_queue.sv -----
// Short queue of classified commands between the front and the engine.
// Depends on bst_pkg for the item type and depth.
module bst_queue import bst_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    output logic  pop_valid,
    input  logic  pop_ready,
    output item_t pop_item
);

    item_t              entry_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_item  = entry_mem[rd_ptr_reg];
    assign do_pop    = pop_valid && pop_ready;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage holds payload only.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- rtl/bst_engine.sv -----
// Back end of the breakpoint slot table: slot modes, slot memory, the
// scanning sequencer and the output register. Depends on bst_pkg.
module bst_engine import bst_pkg::*; #(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    q_valid,
    output logic    q_ready,
    input  item_t   q_item,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_result
);

    localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int HW   = ((IDXW > 6) ? IDXW : 6) + 1;
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(SLOTS - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    typedef struct packed {
        logic [63:0] address;
        logic [31:0] original;
        logic        oneshot;
        logic [31:0] hits;
    } entry_t;

    state_t          state_reg, state_next;
    item_t           item_reg, item_next;
    logic [IDXW-1:0] idx_reg, idx_next;
    result_t         res_reg, res_next;
    logic            out_valid_reg;
    result_t         out_res_reg;
    mode_t           slot_mode_reg [SLOTS];
    entry_t          slot_mem [SLOTS];
    entry_t          rd_data_reg;

    logic            mode_we;
    mode_t           mode_wdata;
    logic            mem_we;
    entry_t          mem_wdata;
    mode_t           cur_mode;
    logic [HW-1:0]   handle_m1;
    logic [HW-1:0]   handle_sum;
    logic [5:0]      hout;
    logic [31:0]     hits_inc;
    logic            load_out;

    assign cur_mode   = slot_mode_reg[idx_reg];
    assign handle_m1  = HW'(q_item.handle) - HW'(1);
    assign handle_sum = HW'(idx_reg) + HW'(1);
    assign hout       = handle_sum[5:0];
    assign hits_inc   = (rd_data_reg.hits == 32'hFFFF_FFFF) ? rd_data_reg.hits
                                                            : rd_data_reg.hits + 32'd1;
    assign load_out   = (state_reg == S_DONE) && (!out_valid_reg || m_ready);

    assign m_valid  = out_valid_reg;
    assign m_result = out_res_reg;

    // Sequencer: one slot is examined per cycle in the scan state.
    always_comb begin
        state_next = state_reg;
        item_next  = item_reg;
        idx_next   = idx_reg;
        res_next   = res_reg;
        q_ready    = 1'b0;
        mode_we    = 1'b0;
        mode_wdata = MODE_FREE;
        mem_we     = 1'b0;
        mem_wdata  = rd_data_reg;
        case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    q_ready   = 1'b1;
                    item_next = q_item;
                    res_next  = '0;
                    case (q_item.kind)
                        KIND_ERR: begin
                            res_next.status = q_item.err_status;
                            state_next      = S_DONE;
                        end
                        KIND_SET, KIND_HIT: begin
                            idx_next   = '0;
                            state_next = S_SCAN;
                        end
                        default: begin
                            idx_next   = handle_m1[IDXW-1:0];
                            state_next = S_SCAN;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                state_next = S_DONE;
                case (item_reg.kind)
                    KIND_SET: begin
                        if (cur_mode == MODE_FREE) begin
                            if (!item_reg.fetch_ok) begin
                                res_next.status = STAT_FAULT;
                            end else begin
                                mode_we                = 1'b1;
                                mode_wdata             = MODE_ACTIVE;
                                mem_we                 = 1'b1;
                                mem_wdata.address      = item_reg.address;
                                mem_wdata.original     = item_reg.word;
                                mem_wdata.oneshot      = item_reg.temporary;
                                mem_wdata.hits         = 32'd0;
                                res_next.handle_out    = hout;
                                res_next.patch_write   = 1'b1;
                                res_next.patch_address = item_reg.address;
                                res_next.patch_word    = BRK_DEBUG;
                            end
                        end else if (idx_reg == LAST_IDX) begin
                            res_next.status = STAT_FULL;
                        end else begin
                            idx_next   = idx_reg + IDXW'(1);
                            state_next = S_SCAN;
                        end
                    end
                    KIND_HIT: begin
                        if ((cur_mode == MODE_ACTIVE) &&
                            (rd_data_reg.address == item_reg.address)) begin
                            mem_we                  = 1'b1;
                            mem_wdata.hits          = hits_inc;
                            res_next.handle_out     = hout;
                            res_next.enter_debugger = 1'b1;
                            res_next.hit_total      = hits_inc;
                            if (rd_data_reg.oneshot) begin
                                mode_we                = 1'b1;
                                mode_wdata             = MODE_FREE;
                                res_next.patch_write   = 1'b1;
                                res_next.patch_address = rd_data_reg.address;
                                res_next.patch_word    = rd_data_reg.original;
                            end
                        end else if (idx_reg == LAST_IDX) begin
                            if (!item_reg.fetch_ok) begin
                                res_next.status = STAT_FAULT;
                            end else if (item_reg.is_brk) begin
                                res_next.enter_debugger = 1'b1;
                            end else begin
                                res_next.status = STAT_UNKNOWN;
                            end
                        end else begin
                            idx_next   = idx_reg + IDXW'(1);
                            state_next = S_SCAN;
                        end
                    end
                    KIND_DELETE: begin
                        if (cur_mode != MODE_FREE) begin
                            mode_we                = 1'b1;
                            mode_wdata             = MODE_FREE;
                            res_next.patch_write   = 1'b1;
                            res_next.patch_address = rd_data_reg.address;
                            res_next.patch_word    = rd_data_reg.original;
                        end else begin
                            res_next.status = STAT_BAD;
                        end
                    end
                    KIND_ENABLE: begin
                        if (cur_mode == MODE_SUSPENDED) begin
                            mode_we                = 1'b1;
                            mode_wdata             = MODE_ACTIVE;
                            res_next.patch_write   = 1'b1;
                            res_next.patch_address = rd_data_reg.address;
                            res_next.patch_word    = BRK_DEBUG;
                        end else begin
                            res_next.status = STAT_BAD;
                        end
                    end
                    KIND_DISABLE: begin
                        if (cur_mode == MODE_ACTIVE) begin
                            mode_we                = 1'b1;
                            mode_wdata             = MODE_SUSPENDED;
                            res_next.patch_write   = 1'b1;
                            res_next.patch_address = rd_data_reg.address;
                            res_next.patch_word    = rd_data_reg.original;
                        end else begin
                            res_next.status = STAT_BAD;
                        end
                    end
                    default: begin
                        res_next.status = STAT_BAD;
                    end
                endcase
            end
            S_DONE: begin
                if (load_out) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and slot modes; reset frees every slot at once.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                slot_mode_reg[i] <= MODE_FREE;
            end
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (mode_we) begin
                slot_mode_reg[idx_reg] <= mode_wdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        idx_reg  <= idx_next;
        res_reg  <= res_next;
        if (load_out) begin
            out_res_reg <= res_reg;
        end
    end

    // Slot memory: one write port, one registered read port that follows
    // the next scan index so the entry is ready in the following cycle.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[idx_reg] <= mem_wdata;
        end
        rd_data_reg <= slot_mem[idx_next];
    end

endmodule

// ----- rtl/breakpoint_slot_table.sv -----
// Top level of the breakpoint slot table: front, command queue and engine.
// Depends on bst_pkg, bst_front, bst_queue and bst_engine.
//
// The table keeps SLOTS software breakpoint slots and answers every input
// beat with exactly one result beat. Set and hit walk the slots one per
// cycle through the single read port of the slot memory. Only one command
// is in the engine at a time; a two-entry queue keeps taking input beats
// while the engine works or a result waits, until the queue is full. Slot
// modes are flip-flops that reset clears all at once, so the block is
// ready right after reset. Patch requests are reported in the result beat
// only.
module breakpoint_slot_table import bst_pkg::*; #(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // address, temporary, handle, fetched_word, fetch_ok
    input  logic [2:0]   s_tuser,   // command
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // handle_out, enter_debugger, patch_write,
                                    // patch_address, patch_word, hit_total
    output logic [2:0]   m_tuser    // status
);

    logic    q_full;
    logic    q_push;
    item_t   q_push_item;
    logic    q_valid;
    logic    q_ready;
    item_t   q_item;
    result_t result;

    bst_front #(.SLOTS(SLOTS)) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_push_item)
    );

    bst_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop_ready (q_ready),
        .pop_item  (q_item)
    );

    bst_engine #(.SLOTS(SLOTS)) u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (result)
    );

    // Result beat packing, lowest field last (handle_out in bits 5:0).
    assign m_tdata = {result.hit_total, result.patch_word, result.patch_address,
                      result.patch_write, result.enter_debugger, result.handle_out};
    assign m_tuser = result.status;

    // A patch request only comes with a successful command.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[7] |-> m_tuser == STAT_OK)
        else $error("patch requested with an error status");

    // Entering the debugger only comes with a successful hit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[6] |-> m_tuser == STAT_OK)
        else $error("debugger entry with an error status");

    // Without a patch request the patch fields read as zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[7] |-> (m_tdata[71:8] == 64'd0) && (m_tdata[103:72] == 32'd0))
        else $error("patch fields set without a patch request");

    // A full queue refuses input beats.
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !s_tready)
        else $error("input taken while the queue is full");

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for breakpoint_slot_table: a directed table, then random beats.
// Depends on bst_pkg and the RTL in rtl/; every result beat is checked against a local
// model of the slot table, or against a typed-in expectation where one is obvious.
module testbench;
    import bst_pkg::*;

    // Command codes that the block does not define; they must be rejected.
    localparam logic [2:0] CMD_SPARE0 = 3'd5;
    localparam logic [2:0] CMD_SPARE2 = 3'd7;
    localparam int RANDOM_BEATS = 1300;
    localparam int PHASE_BEATS  = 100;
    localparam int DRAIN_CYCLES = 40;

    // One row of the directed table.
    typedef struct packed {
        logic [2:0]  cmd;
        logic [63:0] addr;
        logic        temp;
        logic [5:0]  hnd;
        logic [31:0] word;
        logic        ok;
        logic        typed;
        result_t     want;
    } step_row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;   // address, temporary, handle, fetched_word, fetch_ok
    logic [2:0]   s_tuser;   // command
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;   // handle_out, enter_debugger, patch_write,
                             // patch_address, patch_word, hit_total
    logic [2:0]   m_tuser;   // status

    // Local copy of the slot table.
    mode_t       bp_mode  [SLOTS_DEFAULT];
    logic [63:0] bp_addr  [SLOTS_DEFAULT];
    logic [31:0] bp_orig  [SLOTS_DEFAULT];
    logic        bp_once  [SLOTS_DEFAULT];
    logic [31:0] bp_count [SLOTS_DEFAULT];

    result_t   pending_results[$];
    step_row_t directed[$];
    int        mismatch_count;
    bit        no_idle;

    breakpoint_slot_table dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Free-running clock with a period of 10.
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Return a slot to its reset values.
    function automatic void free_slot(int k);
        bp_mode[k]  = MODE_FREE;
        bp_addr[k]  = '0;
        bp_orig[k]  = '0;
        bp_once[k]  = 1'b0;
        bp_count[k] = '0;
    endfunction

    // Compute the result of one command and update the local table.
    function automatic result_t table_response(logic [2:0] cmd, logic [63:0] addr, logic temp,
                                               logic [5:0] hnd, logic [31:0] word, logic ok);
        result_t     r;
        int          idx;
        int          k;
        logic [63:0] trap_addr;
        r = '0;
        idx = -1;
        case (cmd)
            CMD_SET: begin
                if ((addr & ALIGN_MASK) != '0) begin
                    r.status = STAT_MISALIGNED;
                end else begin
                    for (int i = 0; i < SLOTS_DEFAULT; i++)
                        if (idx < 0 && bp_mode[i] == MODE_FREE) idx = i;
                    if (idx < 0) begin
                        r.status = STAT_FULL;
                    end else if (!ok) begin
                        r.status = STAT_FAULT;
                    end else begin
                        bp_mode[idx]    = MODE_ACTIVE;
                        bp_addr[idx]    = addr;
                        bp_orig[idx]    = word;
                        bp_once[idx]    = temp;
                        bp_count[idx]   = '0;
                        r.handle_out    = 6'(idx + 1);
                        r.patch_write   = 1'b1;
                        r.patch_address = addr;
                        r.patch_word    = BRK_DEBUG;
                    end
                end
            end
            CMD_DELETE, CMD_ENABLE, CMD_DISABLE: begin
                if (hnd == 0 || hnd > SLOTS_DEFAULT) begin
                    r.status = STAT_BAD;
                end else begin
                    k = int'(hnd) - 1;
                    if (cmd == CMD_DELETE && bp_mode[k] != MODE_FREE) begin
                        r.patch_write   = 1'b1;
                        r.patch_address = bp_addr[k];
                        r.patch_word    = bp_orig[k];
                        free_slot(k);
                    end else if (cmd == CMD_ENABLE && bp_mode[k] == MODE_SUSPENDED) begin
                        r.patch_write   = 1'b1;
                        r.patch_address = bp_addr[k];
                        r.patch_word    = BRK_DEBUG;
                        bp_mode[k]      = MODE_ACTIVE;
                    end else if (cmd == CMD_DISABLE && bp_mode[k] == MODE_ACTIVE) begin
                        r.patch_write   = 1'b1;
                        r.patch_address = bp_addr[k];
                        r.patch_word    = bp_orig[k];
                        bp_mode[k]      = MODE_SUSPENDED;
                    end else begin
                        r.status = STAT_BAD;
                    end
                end
            end
            CMD_HIT: begin
                // The trap reports the pc after the breakpoint; wrap below 4 is intended.
                trap_addr = addr - INSN_BYTES;
                for (int i = 0; i < SLOTS_DEFAULT; i++)
                    if (idx < 0 && bp_mode[i] == MODE_ACTIVE && bp_addr[i] == trap_addr)
                        idx = i;
                if (idx >= 0) begin
                    if (bp_count[idx] != 32'hFFFF_FFFF) bp_count[idx]++;
                    r.hit_total      = bp_count[idx];
                    r.handle_out     = 6'(idx + 1);
                    r.enter_debugger = 1'b1;
                    if (bp_once[idx]) begin
                        r.patch_write   = 1'b1;
                        r.patch_address = bp_addr[idx];
                        r.patch_word    = bp_orig[idx];
                        free_slot(idx);
                    end
                end else if (!ok) begin
                    r.status = STAT_FAULT;
                end else if (word == BRK_PLAIN || word == BRK_DEBUG) begin
                    r.enter_debugger = 1'b1;
                end else begin
                    r.status = STAT_UNKNOWN;
                end
            end
            default: r.status = STAT_BAD;
        endcase
        return r;
    endfunction

    // Pick a random slot in the wanted mode, or any used slot; -1 if there is none.
    function automatic int pick_slot(mode_t want_mode, bit any_used);
        int start;
        int k;
        int found;
        start = $urandom_range(0, SLOTS_DEFAULT - 1);
        found = -1;
        for (int i = 0; i < SLOTS_DEFAULT; i++) begin
            k = (start + i) % SLOTS_DEFAULT;
            if (found < 0 && (any_used ? bp_mode[k] != MODE_FREE : bp_mode[k] == want_mode))
                found = k;
        end
        return found;
    endfunction

    // Build a typed expectation for the directed table.
    function automatic result_t res(status_t st, logic [5:0] h, logic dbg, logic pw,
                                    logic [63:0] pa, logic [31:0] pword, logic [31:0] tot);
        result_t r;
        r.status         = st;
        r.handle_out     = h;
        r.enter_debugger = dbg;
        r.patch_write    = pw;
        r.patch_address  = pa;
        r.patch_word     = pword;
        r.hit_total      = tot;
        return r;
    endfunction

    task automatic dir_row(input logic [2:0] c, input logic [63:0] a, input logic t,
                           input logic [5:0] h, input logic [31:0] w, input logic ok,
                           input logic typed, input result_t want);
        step_row_t row;
        row.cmd   = c;
        row.addr  = a;
        row.temp  = t;
        row.hnd   = h;
        row.word  = w;
        row.ok    = ok;
        row.typed = typed;
        row.want  = want;
        directed.push_back(row);
    endtask

    // Draw one random command; fill phases lean on set, drain phases on delete.
    task automatic draw_command(input bit filling, output logic [2:0] c, output logic [63:0] a,
                                output logic t, output logic [5:0] h, output logic [31:0] w,
                                output logic ok);
        int pick;
        int roll;
        int k;
        pick = $urandom_range(0, 99);
        roll = $urandom_range(0, 9);
        a    = {$urandom, $urandom};
        t    = ($urandom_range(0, 3) == 0);
        h    = 6'($urandom_range(0, 63));
        w    = $urandom;
        ok   = ($urandom_range(0, 9) != 0);
        if (pick < (filling ? 45 : 15)) begin
            c = CMD_SET;
            if (roll < 6)
                a = 64'h0000_0000_8000_0000 + 64'($urandom_range(0, 15) << 2);
            else if (roll < 8)
                a[1:0] = 2'b00;
            else if (roll == 8)
                a = 64'hFFFF_FFFF_FFFF_FFF0 + 64'($urandom_range(0, 3) << 2);
        end else if (pick < (filling ? 75 : 50)) begin
            c = CMD_HIT;
            k = pick_slot(MODE_ACTIVE, 1'b0);
            if (roll < 7 && k >= 0)
                a = bp_addr[k] + INSN_BYTES;
            else if (roll < 8)
                a = 64'h0000_0000_8000_0004 + 64'($urandom_range(0, 15) << 2);
            else if (roll == 8)
                a = 64'($urandom_range(0, 3) << 2);
            if ($urandom_range(0, 9) < 3)
                w = $urandom_range(0, 1) ? BRK_PLAIN : BRK_DEBUG;
        end else begin
            if (pick < (filling ? 82 : 75)) begin
                c = CMD_DELETE;
                k = pick_slot(MODE_FREE, 1'b1);
            end else if (pick < (filling ? 89 : 84)) begin
                c = CMD_ENABLE;
                k = pick_slot(MODE_SUSPENDED, 1'b0);
            end else if (pick < 96) begin
                c = CMD_DISABLE;
                k = pick_slot(MODE_ACTIVE, 1'b0);
            end else begin
                c = 3'($urandom_range(CMD_SPARE0, CMD_SPARE2));
                k = -1;
            end
            if (roll < 7 && k >= 0) h = 6'(k + 1);
        end
    endtask

    // Drive one input beat and hold it until the block takes it.
    task automatic send_command(input logic [2:0] c, input logic [63:0] a, input logic t,
                                input logic [5:0] h, input logic [31:0] w, input logic ok);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ok, w, h, t, a};
        s_tuser  <= c;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Hold off the sender until every outstanding result has arrived.
    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic check_field(input string what, input logic [63:0] want_v,
                               input logic [63:0] got_v);
        if (want_v !== got_v) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch on %s: expected %h, got %h", what, want_v, got_v);
        end
    endtask

    // Result side: random stalls, then every beat is checked against the oldest expectation.
    initial begin : result_sink
        result_t want;
        int      stall;
        m_tready <= 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result beat with no expectation: status %h data %h",
                             m_tuser, m_tdata);
            end else begin
                want = pending_results.pop_front();
                check_field("status", 64'(want.status), 64'(m_tuser));
                check_field("handle_out", 64'(want.handle_out), 64'(m_tdata[5:0]));
                check_field("enter_debugger", 64'(want.enter_debugger), 64'(m_tdata[6]));
                check_field("patch_write", 64'(want.patch_write), 64'(m_tdata[7]));
                check_field("patch_address", want.patch_address, m_tdata[71:8]);
                check_field("patch_word", 64'(want.patch_word), 64'(m_tdata[103:72]));
                check_field("hit_total", 64'(want.hit_total), 64'(m_tdata[135:104]));
            end
        end
    end

    // Main sequence: reset, directed table, random phases, drain.
    initial begin : stimulus
        logic [2:0]  c;
        logic [63:0] a;
        logic        t;
        logic [5:0]  h;
        logic [31:0] w;
        logic        ok;
        result_t     predicted;
        bit          filling;

        mismatch_count = 0;
        no_idle        = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        for (int i = 0; i < SLOTS_DEFAULT; i++) free_slot(i);

        // Unmatched hits on an empty table: fixed words, read fault, unknown word.
        dir_row(CMD_HIT, 64'h1004, 0, 0, BRK_PLAIN, 1, 1, res(STAT_OK, 0, 1, 0, 0, 0, 0));
        dir_row(CMD_HIT, 64'h2000, 0, 0, BRK_DEBUG, 1, 1, res(STAT_OK, 0, 1, 0, 0, 0, 0));
        dir_row(CMD_HIT, 64'h2000, 0, 0, 32'h0, 0, 1, res(STAT_FAULT, 0, 0, 0, 0, 0, 0));
        dir_row(CMD_HIT, 64'h2000, 0, 0, 32'h1234_5678, 1, 1,
                res(STAT_UNKNOWN, 0, 0, 0, 0, 0, 0));
        // Misaligned sets and a set whose read failed.
        dir_row(CMD_SET, 64'h1001, 0, 0, 32'h0, 1, 1, res(STAT_MISALIGNED, 0, 0, 0, 0, 0, 0));
        dir_row(CMD_SET, 64'h1002, 0, 0, 32'h0, 1, 1, res(STAT_MISALIGNED, 0, 0, 0, 0, 0, 0));
        dir_row(CMD_SET, 64'h1000, 0, 0, 32'h0, 0, 1, res(STAT_FAULT, 0, 0, 0, 0, 0, 0));
        // Two good sets, the second one temporary at the very top of memory.
        dir_row(CMD_SET, 64'h1000, 0, 0, 32'hAAAA_5555, 1, 1,
                res(STAT_OK, 1, 0, 1, 64'h1000, BRK_DEBUG, 0));
        dir_row(CMD_SET, 64'hFFFF_FFFF_FFFF_FFFC, 1, 0, 32'hFFFF_FFFF, 1, 1,
                res(STAT_OK, 2, 0, 1, 64'hFFFF_FFFF_FFFF_FFFC, BRK_DEBUG, 0));
        // A pc of zero wraps onto the temporary slot; then repeated hits on slot 1.
        dir_row(CMD_HIT, 64'h0, 0, 0, 32'h0, 1, 0, '0);
        dir_row(CMD_HIT, 64'h1004, 0, 0, 32'h5A5A_A5A5, 0, 0, '0);
        dir_row(CMD_HIT, 64'h1004, 0, 0, 32'h0, 1, 0, '0);
        // Disable, hit while suspended, enable, with the wrong-state repeats.
        dir_row(CMD_DISABLE, 64'h0, 0, 1, 32'h0, 1, 0, '0);
        dir_row(CMD_DISABLE, 64'h0, 0, 1, 32'h0, 1, 1, res(STAT_BAD, 0, 0, 0, 0, 0, 0));
        dir_row(CMD_HIT, 64'h1004, 0, 0, BRK_DEBUG, 1, 0, '0);
        dir_row(CMD_ENABLE, 64'h0, 0, 1, 32'h0, 1, 0, '0);
        dir_row(CMD_ENABLE, 64'h0, 0, 1, 32'h0, 1, 1, res(STAT_BAD, 0, 0, 0, 0, 0, 0));
        // Handles out of range and a delete of the slot that the temporary hit freed.
        dir_row(CMD_DELETE, 64'h0, 0, 0, 32'h0, 1, 1, res(STAT_BAD, 0, 0, 0, 0, 0, 0));
        dir_row(CMD_DELETE, 64'h0, 0, 33, 32'h0, 1, 1, res(STAT_BAD, 0, 0, 0, 0, 0, 0));
        dir_row(CMD_DELETE, 64'h0, 0, 63, 32'h0, 1, 1, res(STAT_BAD, 0, 0, 0, 0, 0, 0));
        dir_row(CMD_DELETE, 64'h0, 0, 2, 32'h0, 1, 1, res(STAT_BAD, 0, 0, 0, 0, 0, 0));
        dir_row(CMD_DELETE, 64'h0, 0, 1, 32'h0, 1, 0, '0);
        // Codes beyond the defined commands.
        for (int i = CMD_SPARE0; i <= CMD_SPARE2; i++)
            dir_row(3'(i), 64'h0, 0, 1, 32'h0, 1, 1, res(STAT_BAD, 0, 0, 0, 0, 0, 0));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table: the local model always runs to keep its table in step.
        foreach (directed[i]) begin
            send_command(directed[i].cmd, directed[i].addr, directed[i].temp,
                         directed[i].hnd, directed[i].word, directed[i].ok);
            predicted = table_response(directed[i].cmd, directed[i].addr, directed[i].temp,
                                       directed[i].hnd, directed[i].word, directed[i].ok);
            pending_results.push_back(directed[i].typed ? directed[i].want : predicted);
        end
        wait_all_results();

        // Random phases alternate between filling and draining the table.
        filling = 1'b1;
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % PHASE_BEATS == 0 && n != 0) begin
                filling = !filling;
                wait_all_results();
            end
            if (n % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
            draw_command(filling, c, a, t, h, w, ok);
            send_command(c, a, t, h, w, ok);
            pending_results.push_back(table_response(c, a, t, h, w, ok));
        end
        s_tvalid <= 1'b0;
        no_idle = 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("PASS breakpoint_slot_table");
        else
            $display("FAIL breakpoint_slot_table");
        $finish;
    end

    // Watchdog: several times the slowest correct run.
    initial begin : watchdog
        #5_000_000;
        $display("FAIL breakpoint_slot_table");
        $finish;
    end

endmodule
